[rtl/core/wict_pkg.sv]
// Shared types and constants of the wide identifier compaction table.
package wict_pkg;

  // Key store geometry
  localparam int unsigned ENTRIES = 64;
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);

  // First number handed out dynamically
  localparam logic [31:0] FIRST_DYNAMIC = 32'hf000_0000;

  // Result status codes
  localparam logic [2:0] ST_PASS  = 3'd0;
  localparam logic [2:0] ST_FOUND = 3'd1;
  localparam logic [2:0] ST_NEW   = 3'd2;
  localparam logic [2:0] ST_FULL  = 3'd3;
  localparam logic [2:0] ST_WIDE  = 3'd4;

  // Kind of result chosen by the controller
  typedef enum logic [1:0] {
    RES_DIRECT,
    RES_HIT,
    RES_NEW,
    RES_FULL
  } res_e;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LOAD
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_key;
    logic issue_read;
    logic capture;
    res_e res_kind;
    logic load_out;
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic direct;
    logic hit;
    logic scan_end;
    logic full;
    logic out_busy;
  } dp_status_t;

endpackage

[rtl/core/wict_ctrl.sv]
// Controller state machine: sequences accept, key scan and result load.
module wict_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  wict_pkg::dp_status_t status_i,
  output wict_pkg::ctrl_cmd_t  cmd_o
);

  wict_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wict_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      wict_pkg::S_IDLE: begin
        if (in_valid_i) state_d = wict_pkg::S_SCAN;
      end
      wict_pkg::S_SCAN: begin
        if (status_i.direct || status_i.hit || status_i.scan_end) state_d = wict_pkg::S_LOAD;
      end
      wict_pkg::S_LOAD: begin
        if (!status_i.out_busy) state_d = wict_pkg::S_IDLE;
      end
      default: state_d = wict_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o        = 1'b0;
    cmd_o.load_key    = 1'b0;
    cmd_o.issue_read  = 1'b0;
    cmd_o.capture     = 1'b0;
    cmd_o.res_kind    = wict_pkg::RES_DIRECT;
    cmd_o.load_out    = 1'b0;
    case (state_q)
      wict_pkg::S_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.load_key = in_valid_i;
      end
      wict_pkg::S_SCAN: begin
        // Pass-through first, then a match, then end of the used slots
        if (status_i.direct) begin
          cmd_o.capture  = 1'b1;
          cmd_o.res_kind = wict_pkg::RES_DIRECT;
        end else if (status_i.hit) begin
          cmd_o.capture  = 1'b1;
          cmd_o.res_kind = wict_pkg::RES_HIT;
        end else if (status_i.scan_end) begin
          cmd_o.capture  = 1'b1;
          cmd_o.res_kind = status_i.full ? wict_pkg::RES_FULL : wict_pkg::RES_NEW;
        end else begin
          cmd_o.issue_read = 1'b1;
        end
      end
      wict_pkg::S_LOAD: begin
        cmd_o.load_out = !status_i.out_busy;
      end
      default: ;
    endcase
  end

endmodule

[rtl/core/wict_dp.sv]
// Datapath: key register, key store memory, scan pointer, fill count and output register.
module wict_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 large_fs_we_i,
  input  logic                 large_fs_i,
  input  logic [63:0]          file_number_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [31:0]          mapped_number_o,
  output logic [2:0]           status_o,
  input  wict_pkg::ctrl_cmd_t  cmd_i,
  output wict_pkg::dp_status_t status_dp_o
);

  logic                       large_fs_q;
  logic [63:0]                key_q;
  logic                       direct_q, wide_q;
  logic [wict_pkg::CNT_W-1:0] ptr_q, cnt_q;
  logic [63:0]                rd_data_q;
  logic                       rd_vld_q;
  logic [wict_pkg::IDX_W-1:0] rd_slot_q;
  wict_pkg::res_e             res_kind_q;
  logic [wict_pkg::IDX_W-1:0] hit_slot_q;
  logic                       out_valid_q;
  logic [31:0]                mapped_q, mapped_d;
  logic [2:0]                 status_q, status_d;
  logic                       below_first;
  logic                       hit;

  logic [63:0] mem [wict_pkg::ENTRIES];

  // Mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      large_fs_q <= 1'b0;
    end else if (large_fs_we_i) begin
      large_fs_q <= large_fs_i;
    end
  end

  // Classify the item as it is accepted
  assign below_first = (file_number_i[63:32] == 32'd0) &&
                       (file_number_i[31:0] < wict_pkg::FIRST_DYNAMIC);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_key) begin
      key_q    <= file_number_i;
      direct_q <= !large_fs_q || below_first;
      wide_q   <= !large_fs_q && (file_number_i[63:32] != 32'd0);
    end
  end

  // Scan pointer and read tag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.issue_read;
      if (cmd_i.load_key) begin
        ptr_q <= '0;
      end else if (cmd_i.issue_read) begin
        ptr_q <= ptr_q + 1'b1;
      end
    end
  end

  // Key store: one registered read, one append write
  always_ff @(posedge clk_i) begin
    if (cmd_i.issue_read) begin
      rd_data_q <= mem[ptr_q[wict_pkg::IDX_W-1:0]];
      rd_slot_q <= ptr_q[wict_pkg::IDX_W-1:0];
    end
    if (cmd_i.load_out && (res_kind_q == wict_pkg::RES_NEW)) begin
      mem[cnt_q[wict_pkg::IDX_W-1:0]] <= key_q;
    end
  end

  // Fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.load_out && (res_kind_q == wict_pkg::RES_NEW)) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  assign hit = rd_vld_q && (rd_data_q == key_q);

  // Result kind and matching slot
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      res_kind_q <= cmd_i.res_kind;
      hit_slot_q <= rd_slot_q;
    end
  end

  // Result formatting
  always_comb begin
    mapped_d = 32'd0;
    status_d = wict_pkg::ST_PASS;
    case (res_kind_q)
      wict_pkg::RES_DIRECT: begin
        mapped_d = key_q[31:0];
        status_d = wide_q ? wict_pkg::ST_WIDE : wict_pkg::ST_PASS;
      end
      wict_pkg::RES_HIT: begin
        mapped_d = wict_pkg::FIRST_DYNAMIC + 32'(hit_slot_q);
        status_d = wict_pkg::ST_FOUND;
      end
      wict_pkg::RES_NEW: begin
        mapped_d = wict_pkg::FIRST_DYNAMIC + 32'(cnt_q[wict_pkg::IDX_W-1:0]);
        status_d = wict_pkg::ST_NEW;
      end
      wict_pkg::RES_FULL: begin
        mapped_d = 32'd0;
        status_d = wict_pkg::ST_FULL;
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      mapped_q <= mapped_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign mapped_number_o = mapped_q;
  assign status_o        = status_q;

  // Status to controller
  assign status_dp_o.direct   = direct_q;
  assign status_dp_o.hit      = hit;
  assign status_dp_o.scan_end = (ptr_q == cnt_q);
  assign status_dp_o.full     = (cnt_q == wict_pkg::CNT_W'(wict_pkg::ENTRIES));
  assign status_dp_o.out_busy = out_valid_q && !out_ready_i;

  // Checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= wict_pkg::CNT_W'(wict_pkg::ENTRIES))
    else $error("fill count beyond store size");

  a_read_in_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.issue_read |-> (ptr_q < cnt_q))
    else $error("read of an unused slot");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> !(out_valid_q && !out_ready_i))
    else $error("result loaded over a waiting item");

  a_append_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_out && (res_kind_q == wict_pkg::RES_NEW)) |=>
      (cnt_q == $past(cnt_q) + 1'b1))
    else $error("append did not advance fill count");

endmodule

[rtl/core/wide_id_compaction_table.sv]
// Top level: maps 64-bit identifiers onto 32-bit ones through a bounded key store.
// Pass-through and too-wide items are settled without a scan; a lookup scans up to N stored
//   keys in order and stops at a match, N being the number of stored keys (N <= 64).
// One item at a time: a new one is accepted only after the result is loaded; the key store has
//   one read port and the scan compares one stored key per cycle.
// Reset (asynchronous, active low) empties the table, clears the mode and the output.
module wide_id_compaction_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        large_fs_we_i,
  input  logic        large_fs_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] file_number_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] mapped_number_o,
  output logic [2:0]  status_o
);

  wict_pkg::ctrl_cmd_t  cmd;
  wict_pkg::dp_status_t dp_status;

  // Sequencer
  wict_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (dp_status),
    .cmd_o      (cmd)
  );

  // Storage and result path
  wict_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .large_fs_we_i   (large_fs_we_i),
    .large_fs_i      (large_fs_i),
    .file_number_i   (file_number_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .mapped_number_o (mapped_number_o),
    .status_o        (status_o),
    .cmd_i           (cmd),
    .status_dp_o     (dp_status)
  );

endmodule
